// ===== rtl/rfbs_pkg.sv =====
`default_nettype none

package rfbs_pkg;

  localparam logic [9:0] MAX_WIDTH  = 10'd320;
  localparam logic [9:0] MAX_HEIGHT = 10'd240;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic [7:0] BUS_CMD_COLUMN = 8'h2A;
  localparam logic [7:0] BUS_CMD_PAGE   = 8'h2B;
  localparam logic [7:0] BUS_CMD_WRITE  = 8'h2C;

  typedef struct packed {
    logic       cmd;
    logic [8:0] start_x;
    logic [7:0] start_y;
    logic [8:0] width;
    logic [7:0] height;
    logic [4:0] red;
    logic [5:0] green;
    logic [4:0] blue;
  } req_t;

  typedef struct packed {
    logic        is_data;
    logic [15:0] bus_word;
    logic        last;
  } rsp_t;

  typedef enum logic [3:0] {
    SEL_COL_CMD   = 4'd0,
    SEL_COL_SH    = 4'd1,
    SEL_COL_SL    = 4'd2,
    SEL_COL_EH    = 4'd3,
    SEL_COL_EL    = 4'd4,
    SEL_PAGE_CMD  = 4'd5,
    SEL_PAGE_SH   = 4'd6,
    SEL_PAGE_SL   = 4'd7,
    SEL_PAGE_EH   = 4'd8,
    SEL_PAGE_EL   = 4'd9,
    SEL_WRITE_CMD = 4'd10,
    SEL_PIXEL     = 4'd11
  } word_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    logic      dec;
    logic      last;
    word_sel_t sel;
  } rfbs_ctrl_t;

  typedef struct packed {
    logic pix_zero;
    logic pix_last;
    logic out_full;
  } rfbs_status_t;

endpackage

`default_nettype wire

// ===== rtl/rfbs_ctrl.sv =====
`default_nettype none

module rfbs_ctrl import rfbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         req_valid,
  input  logic         req_cmd,
  input  logic         rsp_ready,
  input  rfbs_status_t status,
  output logic         req_ready,
  output rfbs_ctrl_t   ctrl
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_HEADER = 3'b010,
    ST_PIXELS = 3'b100
  } state_t;

  state_t     state, state_next;
  word_sel_t  phase, phase_next;
  logic       accept, step, load;

  assign req_ready = !status.out_full || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign step      = accept && (req_cmd == CMD_STEP);
  assign load      = accept && (req_cmd == CMD_LOAD) && (state == ST_IDLE);

  always_comb begin
    state_next = state;
    phase_next = phase;
    unique case (state)
      ST_IDLE: begin
        if (load) begin
          state_next = ST_HEADER;
          phase_next = SEL_COL_CMD;
        end
      end
      ST_HEADER: begin
        if (step) begin
          if (phase == SEL_WRITE_CMD) begin
            phase_next = SEL_COL_CMD;
            state_next = status.pix_zero ? ST_IDLE : ST_PIXELS;
          end else begin
            phase_next = word_sel_t'(phase + 4'd1);
          end
        end
      end
      ST_PIXELS: begin
        if (step && status.pix_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
        phase_next = SEL_COL_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= SEL_COL_CMD;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  always_comb begin
    ctrl.load = load;
    ctrl.emit = step && (state != ST_IDLE);
    ctrl.dec  = step && (state == ST_PIXELS);
    ctrl.last = step && (state == ST_PIXELS) && status.pix_last;
    ctrl.sel  = (state == ST_PIXELS) ? SEL_PIXEL : phase;
  end

endmodule

`default_nettype wire

// ===== rtl/rfbs_datapath.sv =====
`default_nettype none

module rfbs_datapath import rfbs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  req_t         req,
  input  rfbs_ctrl_t   ctrl,
  input  logic         rsp_ready,
  output logic         rsp_valid,
  output rsp_t         rsp,
  output rfbs_status_t status
);

  logic [9:0]  col_start, col_end, page_start, page_end;
  logic [15:0] pixel_colour;
  logic [16:0] pixels_left;
  logic [9:0]  w_sat, h_sat;
  logic [19:0] area;
  rsp_t        word;

  assign w_sat = ({1'b0, req.width} > MAX_WIDTH) ? MAX_WIDTH : {1'b0, req.width};
  assign h_sat = ({2'b00, req.height} > MAX_HEIGHT) ? MAX_HEIGHT : {2'b00, req.height};
  assign area  = {10'd0, w_sat} * {10'd0, h_sat};

  always_ff @(posedge clk) begin
    if (rst) begin
      col_start    <= '0;
      col_end      <= '0;
      page_start   <= '0;
      page_end     <= '0;
      pixel_colour <= '0;
      pixels_left  <= '0;
    end else if (ctrl.load) begin
      col_start    <= {1'b0, req.start_x};
      col_end      <= {1'b0, req.start_x} + w_sat - 10'd1;
      page_start   <= {2'b00, req.start_y};
      page_end     <= {2'b00, req.start_y} + h_sat - 10'd1;
      pixel_colour <= {req.red, req.green, req.blue};
      pixels_left  <= area[16:0];
    end else if (ctrl.dec && (pixels_left != 17'd0)) begin
      pixels_left  <= pixels_left - 17'd1;
    end
  end

  always_comb begin
    word.is_data  = 1'b1;
    word.last     = ctrl.last;
    word.bus_word = '0;
    unique case (ctrl.sel)
      SEL_COL_CMD: begin
        word.is_data  = 1'b0;
        word.bus_word = {8'h00, BUS_CMD_COLUMN};
      end
      SEL_COL_SH:  word.bus_word = {14'd0, col_start[9:8]};
      SEL_COL_SL:  word.bus_word = {8'h00, col_start[7:0]};
      SEL_COL_EH:  word.bus_word = {14'd0, col_end[9:8]};
      SEL_COL_EL:  word.bus_word = {8'h00, col_end[7:0]};
      SEL_PAGE_CMD: begin
        word.is_data  = 1'b0;
        word.bus_word = {8'h00, BUS_CMD_PAGE};
      end
      SEL_PAGE_SH: word.bus_word = {14'd0, page_start[9:8]};
      SEL_PAGE_SL: word.bus_word = {8'h00, page_start[7:0]};
      SEL_PAGE_EH: word.bus_word = {14'd0, page_end[9:8]};
      SEL_PAGE_EL: word.bus_word = {8'h00, page_end[7:0]};
      SEL_WRITE_CMD: begin
        word.is_data  = 1'b0;
        word.bus_word = {8'h00, BUS_CMD_WRITE};
      end
      SEL_PIXEL:   word.bus_word = pixel_colour;
      default:     word.bus_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      rsp <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign status.pix_zero = (pixels_left == 17'd0);
  assign status.pix_last = (pixels_left == 17'd1);
  assign status.out_full = rsp_valid;

endmodule

`default_nettype wire

// ===== rtl/rectangle_fill_bus_sequencer_unit.sv =====
// Rectangle fill bus sequencer.
// The request channel (req_valid, req_ready, req) carries two kinds of request.
// A load request (cmd 0) sets the window corner, size and 5-6-5 colour; it is
// ignored while a fill is in progress and never produces a response.
// A step request (cmd 1) produces one bus write on the response channel
// (rsp_valid, rsp_ready, rsp): command 0x2A and four column bytes, command
// 0x2B and four page bytes, command 0x2C, then width times height colour
// words (width clamped to 320, height to 240), the last one flagged. A step
// with no fill in progress is dropped. The response appears in the output
// register in the cycle after its step is accepted, so one write per cycle is
// sustained while rsp_ready stays high. The rate is set by the one-entry output
// register: while it holds a response that the receiver stalls, req_ready stays
// low, and it rises again in the cycle the receiver takes the response.
// Reset clears the sequencer to idle with no fill loaded and drops any
// response still held in the output register.
`default_nettype none

module rectangle_fill_bus_sequencer_unit import rfbs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  rfbs_ctrl_t   ctrl;
  rfbs_status_t status;

  rfbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .rsp_ready (rsp_ready),
    .status    (status),
    .req_ready (req_ready),
    .ctrl      (ctrl)
  );

  rfbs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .status    (status)
  );

`ifndef ASSERT_OFF
  a_emit_on_accept: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |-> (req_valid && req_ready && req.cmd == CMD_STEP))
    else $error("bus write issued without an accepted step request");

  a_load_no_emit: assert property (@(posedge clk) disable iff (rst)
    !(ctrl.load && ctrl.emit))
    else $error("load and bus write in the same cycle");

  a_emit_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> (rsp_valid && rsp.last == $past(ctrl.last)))
    else $error("bus write not presented on the response channel");

  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.last) |-> rsp.is_data)
    else $error("last flag on a command byte");
`endif

endmodule

`default_nettype wire
